@@ hw/rtl/mbfa_pkg.sv @@
// Package for the mark bitmap free area extractor.
// Field widths, command and result codes, result and sweep state types.
// No dependencies.
`default_nettype none

package mbfa_pkg;

	localparam int CARD_W = 13;
	localparam int LEN_W  = 14;
	localparam int CNT_W  = 13;

	localparam int CARDS_PER_BLOCK_DEF = 8192;
	localparam logic [LEN_W-1:0] MIN_FREE_RESET = 14'd32;
	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic CMD_MARK = 1'b0;
	localparam logic CMD_END  = 1'b1;

	localparam logic KIND_AREA    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam int RES_FIFO_DEPTH = 4;
	localparam int RES_PTR_W = $clog2(RES_FIFO_DEPTH);

	typedef struct packed {
		logic              kind;
		logic [CARD_W-1:0] start_card;
		logic [LEN_W-1:0]  cards;
		logic [CNT_W-1:0]  total;
		logic [LEN_W-1:0]  free_total;
		logic              last;
	} result_t;

	typedef struct packed {
		logic [LEN_W-1:0]  scan;
		logic              have_prev;
		logic [LEN_W-1:0]  prev_rem;
		logic [CNT_W-1:0]  area_cnt;
		logic [LEN_W-1:0]  free_sum;
		logic [CARD_W-1:0] first_start;
		logic [LEN_W-1:0]  first_len;
	} sweep_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/mbfa_sweep_core.sv @@
// Gap check and state update for one item of the free area sweep.
// Combinational; depends on mbfa_pkg.
`default_nettype none

module mbfa_sweep_core #(
	parameter int CARDS_PER_BLOCK = mbfa_pkg::CARDS_PER_BLOCK_DEF
) (
	input  mbfa_pkg::sweep_state_t             state,
	input  logic [mbfa_pkg::LEN_W-1:0]         min_free,
	input  logic                               cmd,
	input  logic [mbfa_pkg::CARD_W-1:0]        card,
	input  logic [mbfa_pkg::LEN_W-1:0]         size,
	output mbfa_pkg::sweep_state_t             state_next,
	output mbfa_pkg::result_t                  res0,
	output mbfa_pkg::result_t                  res1,
	output logic [1:0]                         push_cnt
);

	localparam int END_W = $clog2(CARDS_PER_BLOCK + 1);
	localparam int CW = (END_W > mbfa_pkg::LEN_W + 1) ? END_W : mbfa_pkg::LEN_W + 1;
	localparam logic [CW-1:0] BLOCK_END = CW'(CARDS_PER_BLOCK);
	localparam logic [CW-1:0] LEN_MAX_W = CW'(mbfa_pkg::LEN_MAX);

	logic [CW-1:0]                  end_w, scan_w, rem_w, gap, gap2, min_w;
	logic [CW-1:0]                  start_w;
	logic                           in_block, rem_blocks, found;
	logic [mbfa_pkg::LEN_W-1:0]     len;
	logic [mbfa_pkg::LEN_W:0]       sum_ext;
	mbfa_pkg::sweep_state_t         upd;
	mbfa_pkg::result_t              area, summary;

	always_comb begin
		scan_w   = CW'(state.scan);
		rem_w    = state.have_prev ? CW'(state.prev_rem) : '0;
		end_w    = (cmd == mbfa_pkg::CMD_END) ? BLOCK_END : CW'(card);
		in_block = (cmd == mbfa_pkg::CMD_END) || (CW'(card) < BLOCK_END);
		gap      = (end_w > scan_w) ? end_w - scan_w : '0;
		rem_blocks = rem_w > gap;
		gap2     = gap - rem_w;
		start_w  = scan_w + rem_w;
		min_w    = (min_free == '0) ? CW'(1) : CW'(min_free);
		found    = in_block && !rem_blocks && (gap2 >= min_w);
		len      = (gap2 > LEN_MAX_W) ? mbfa_pkg::LEN_MAX : gap2[mbfa_pkg::LEN_W-1:0];
		sum_ext  = {1'b0, state.free_sum} + {1'b0, len};

		upd = state;
		if (found) begin
			if (state.area_cnt == '0) begin
				upd.first_start = start_w[mbfa_pkg::CARD_W-1:0];
				upd.first_len   = len;
			end
			if (state.area_cnt != mbfa_pkg::CNT_MAX)
				upd.area_cnt = state.area_cnt + 1'b1;
			upd.free_sum = sum_ext[mbfa_pkg::LEN_W] ? mbfa_pkg::LEN_MAX
				: sum_ext[mbfa_pkg::LEN_W-1:0];
		end

		area.kind       = mbfa_pkg::KIND_AREA;
		area.start_card = start_w[mbfa_pkg::CARD_W-1:0];
		area.cards      = len;
		area.total      = '0;
		area.free_total = '0;
		area.last       = 1'b0;

		summary.kind       = mbfa_pkg::KIND_SUMMARY;
		summary.start_card = upd.first_start;
		summary.cards      = upd.first_len;
		summary.total      = upd.area_cnt;
		summary.free_total = upd.free_sum;
		summary.last       = 1'b1;

		state_next = upd;
		res0 = area;
		res1 = summary;
		push_cnt = 2'd0;
		if (cmd == mbfa_pkg::CMD_END) begin
			state_next = '0;
			if (found) begin
				push_cnt = 2'd2;
			end else begin
				res0 = summary;
				push_cnt = 2'd1;
			end
		end else if (in_block) begin
			state_next.have_prev = 1'b1;
			state_next.prev_rem  = (size == '0) ? '0 : size - 1'b1;
			state_next.scan      = {1'b0, card} + 1'b1;
			push_cnt = found ? 2'd1 : 2'd0;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/mbfa_result_fifo.sv @@
// Small result queue taking up to two results per cycle, one out per cycle.
// Depends on mbfa_pkg.
`default_nettype none

module mbfa_result_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [1:0]             push_cnt,
	input  mbfa_pkg::result_t      push0,
	input  mbfa_pkg::result_t      push1,
	input  logic                   pop,
	output logic                   room2,
	output logic                   not_empty,
	output mbfa_pkg::result_t      head
);

	localparam int PW = mbfa_pkg::RES_PTR_W;

	mbfa_pkg::result_t mem_q [mbfa_pkg::RES_FIFO_DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [PW:0]       count_q;
	logic              do_pop;

	assign not_empty = count_q != '0;
	assign room2     = count_q <= (PW+1)'(mbfa_pkg::RES_FIFO_DEPTH - 2);
	assign head      = mem_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0)
			mem_q[wr_ptr_q] <= push0;
		if (push_cnt == 2'd2)
			mem_q[wr_ptr_q + 1'b1] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push_cnt);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (PW+1)'(push_cnt) - (PW+1)'(do_pop);
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/mark_bitmap_free_area_extractor.sv @@
// Top level of the mark bitmap free area extractor.
// Depends on mbfa_pkg, mbfa_sweep_core and mbfa_result_fifo.
//
// Takes one item per cycle unless stalled: an input register feeds the gap
// check, and its results are written into a four-entry result queue. A
// live-object item gives at most one result; an end-of-block item gives
// the summary, preceded by a free area when the gap up to the block end
// qualifies. The output port delivers one result per cycle while out_stall
// is low, so a block end with a final area needs one extra output transfer.
// Input stalls while an item waits in the input register and the queue has
// fewer than two free entries.
`default_nettype none

module mark_bitmap_free_area_extractor #(
	parameter int CARDS_PER_BLOCK = mbfa_pkg::CARDS_PER_BLOCK_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [mbfa_pkg::LEN_W-1:0]    cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [mbfa_pkg::CARD_W-1:0]   card_index,
	input  logic [mbfa_pkg::LEN_W-1:0]    object_cards,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          kind,
	output logic [mbfa_pkg::CARD_W-1:0]   area_start_card,
	output logic [mbfa_pkg::LEN_W-1:0]    area_cards,
	output logic [mbfa_pkg::CNT_W-1:0]    area_total,
	output logic [mbfa_pkg::LEN_W-1:0]    free_cards_total,
	output logic                          last
);

	logic [mbfa_pkg::LEN_W-1:0]   min_free_q;
	logic                         valid_s1;
	logic                         cmd_s1;
	logic [mbfa_pkg::CARD_W-1:0]  card_s1;
	logic [mbfa_pkg::LEN_W-1:0]   size_s1;
	mbfa_pkg::sweep_state_t       state_q, state_next;
	mbfa_pkg::result_t            res0, res1, head;
	logic [1:0]                   core_push;
	logic                         room2, proc, in_xfer;

	assign proc     = valid_s1 && room2;
	assign in_stall = valid_s1 && !room2;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_free_q <= mbfa_pkg::MIN_FREE_RESET;
			valid_s1   <= 1'b0;
			state_q    <= '0;
		end else begin
			if (cfg_wr_en)
				min_free_q <= cfg_wr_data;
			if (in_xfer)
				valid_s1 <= 1'b1;
			else if (proc)
				valid_s1 <= 1'b0;
			if (proc)
				state_q <= state_next;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1  <= cmd;
			card_s1 <= card_index;
			size_s1 <= object_cards;
		end
	end

	mbfa_sweep_core #(
		.CARDS_PER_BLOCK(CARDS_PER_BLOCK)
	) u_core (
		.state      (state_q),
		.min_free   (min_free_q),
		.cmd        (cmd_s1),
		.card       (card_s1),
		.size       (size_s1),
		.state_next (state_next),
		.res0       (res0),
		.res1       (res1),
		.push_cnt   (core_push)
	);

	mbfa_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (proc ? core_push : 2'd0),
		.push0     (res0),
		.push1     (res1),
		.pop       (!out_stall),
		.room2     (room2),
		.not_empty (out_valid),
		.head      (head)
	);

	assign kind             = head.kind;
	assign area_start_card  = head.start_card;
	assign area_cards       = head.cards;
	assign area_total       = head.total;
	assign free_cards_total = head.free_total;
	assign last             = head.last;

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for mark_bitmap_free_area_extractor.
// Sweeps directed and random heap blocks, predicts areas and summaries in-line.
// Depends on mbfa_pkg and the extractor RTL.
`timescale 1ns / 1ps

module tb;
	localparam int CARD_W = mbfa_pkg::CARD_W;
	localparam int LEN_W  = mbfa_pkg::LEN_W;
	localparam int CNT_W  = mbfa_pkg::CNT_W;
	localparam logic [LEN_W-1:0] LEN_MAX = mbfa_pkg::LEN_MAX;
	localparam logic [CNT_W-1:0] CNT_MAX = mbfa_pkg::CNT_MAX;
	localparam logic CMD_MARK     = mbfa_pkg::CMD_MARK;
	localparam logic CMD_END      = mbfa_pkg::CMD_END;
	localparam logic KIND_AREA    = mbfa_pkg::KIND_AREA;
	localparam logic KIND_SUMMARY = mbfa_pkg::KIND_SUMMARY;

	typedef mbfa_pkg::result_t result_t;

	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 8;
	localparam int BLOCK_CARDS = mbfa_pkg::CARDS_PER_BLOCK_DEF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [LEN_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic cmd = CMD_MARK;
	logic [CARD_W-1:0] card_index = '0;
	logic [LEN_W-1:0] object_cards = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic kind;
	logic [CARD_W-1:0] area_start_card;
	logic [LEN_W-1:0] area_cards;
	logic [CNT_W-1:0] area_total;
	logic [LEN_W-1:0] free_cards_total;
	logic last;

	// sweep predictor state
	int sw_min = 32;
	int sw_scan = 0;
	bit sw_have_prev = 1'b0;
	int sw_prev_rem = 0;
	int sw_areas = 0;
	int sw_free = 0;
	int sw_first_start = 0;
	int sw_first_len = 0;

	result_t pending_results[$];

	int mismatches = 0;
	int items_sent = 0;
	int blocks_swept = 0;
	int areas_seen = 0;
	int summaries_seen = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	bit rx_quiet = 1'b0;
	int rx_left = 0;
	int quiet_cycles = 0;

	mark_bitmap_free_area_extractor u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.card_index(card_index),
		.object_cards(object_cards),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.area_start_card(area_start_card),
		.area_cards(area_cards),
		.area_total(area_total),
		.free_cards_total(free_cards_total),
		.last(last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void sweep_clear();
		sw_scan = 0;
		sw_have_prev = 1'b0;
		sw_prev_rem = 0;
		sw_areas = 0;
		sw_free = 0;
		sw_first_start = 0;
		sw_first_len = 0;
	endfunction

	// gap up to end_card, less the previous object's remainder
	function automatic bit find_area(input int end_card, output result_t r);
		int gap;
		int start;
		int minimum;
		int len;
		r = '0;
		gap = (end_card > sw_scan) ? end_card - sw_scan : 0;
		start = sw_scan;
		minimum = (sw_min == 0) ? 1 : sw_min;
		if (sw_have_prev) begin
			if (sw_prev_rem > gap)
				return 1'b0;
			gap -= sw_prev_rem;
			start += sw_prev_rem;
		end
		if (gap < minimum)
			return 1'b0;
		len = (gap > int'(LEN_MAX)) ? int'(LEN_MAX) : gap;
		if (sw_areas == 0) begin
			sw_first_start = start & int'(CNT_MAX);
			sw_first_len = len;
		end
		if (sw_areas < int'(CNT_MAX))
			sw_areas++;
		sw_free += len;
		if (sw_free > int'(LEN_MAX))
			sw_free = int'(LEN_MAX);
		r.kind = KIND_AREA;
		r.start_card = start[CARD_W-1:0];
		r.cards = len[LEN_W-1:0];
		return 1'b1;
	endfunction

	function automatic void sweep_item(input logic c, input logic [CARD_W-1:0] card,
			input logic [LEN_W-1:0] sz);
		result_t r;
		if (c == CMD_MARK) begin
			if (int'(card) >= BLOCK_CARDS)
				return;
			if (find_area(int'(card), r))
				pending_results.push_back(r);
			sw_have_prev = 1'b1;
			sw_prev_rem = (sz == 0) ? 0 : int'(sz) - 1;
			sw_scan = int'(card) + 1;
		end else begin
			if (find_area(BLOCK_CARDS, r))
				pending_results.push_back(r);
			r = '0;
			r.kind = KIND_SUMMARY;
			r.start_card = sw_first_start[CARD_W-1:0];
			r.cards = sw_first_len[LEN_W-1:0];
			r.total = sw_areas[CNT_W-1:0];
			r.free_total = sw_free[LEN_W-1:0];
			r.last = 1'b1;
			pending_results.push_back(r);
			sweep_clear();
		end
	endfunction

	function automatic void check_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		result_t r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected");
				mismatches++;
			end else begin
				r = pending_results.pop_front();
				check_field("kind", r.kind, kind);
				check_field("area_start_card", r.start_card, area_start_card);
				check_field("area_cards", r.cards, area_cards);
				check_field("area_total", r.total, area_total);
				check_field("free_cards_total", r.free_total, free_cards_total);
				check_field("last", r.last, last);
				if (kind == KIND_SUMMARY)
					summaries_seen++;
				else
					areas_seen++;
			end
		end
	end

	// receiver stall bursts
	always @(posedge clk) begin
		if (rx_left > 0)
			rx_left--;
		if (rx_quiet) begin
			out_stall <= 1'b0;
		end else if (rx_left == 0) begin
			if ($urandom_range(0, 99) < rx_stall_pct) begin
				out_stall <= 1'b1;
				rx_left = $urandom_range(1, 15);
			end else begin
				out_stall <= 1'b0;
				rx_left = $urandom_range(1, 20);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$error("no transfer for %0d cycles", quiet_cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send_item(input logic c, input logic [CARD_W-1:0] card,
			input logic [LEN_W-1:0] sz);
		if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		card_index <= card;
		object_cards <= sz;
		do @(posedge clk); while (in_stall);
		sweep_item(c, card, sz);
		items_sent++;
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_min(input logic [LEN_W-1:0] v);
		hold_until_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sw_min = int'(v);
	endtask

	function automatic int pick_min();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 1;
			2: return int'(LEN_MAX);
			3: return BLOCK_CARDS;
			4, 5, 6: return $urandom_range(1, 64);
			7, 8: return $urandom_range(2, 400);
			default: return $urandom_range(1, BLOCK_CARDS);
		endcase
	endfunction

	task automatic sweep_block(input bit noisy);
		int pos;
		int gap;
		int card;
		int sz;
		int n;
		int last_card;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 20);
		pos = 0;
		last_card = 0;
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 9))
				0, 1: gap = 0;
				2, 3, 4: gap = sw_min - 2 + $urandom_range(0, 4);
				5, 6, 7: gap = $urandom_range(1, 64);
				8: gap = $urandom_range(0, BLOCK_CARDS - 1 - pos);
				default: gap = $urandom_range(1, 8);
			endcase
			if (gap < 0)
				gap = 0;
			card = pos + gap;
			sz = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 12);
			if (noisy && $urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 3))
					0: card = $urandom_range(0, BLOCK_CARDS - 1);
					1: sz = $urandom_range(0, int'(LEN_MAX));
					2: sz = 0;
					default: card = $urandom_range(0, last_card);
				endcase
			end
			if (card > BLOCK_CARDS - 1)
				break;
			send_item(CMD_MARK, card[CARD_W-1:0], sz[LEN_W-1:0]);
			last_card = card;
			pos = card + ((sz == 0) ? 1 : sz);
			if (pos > BLOCK_CARDS - 1)
				break;
		end
		send_item(CMD_END, CARD_W'($urandom), LEN_W'($urandom));
		blocks_swept++;
	endtask

	// reset minimum, a few objects, qualifying and short gaps
	task automatic test_basic_sweep();
		send_item(CMD_MARK, 13'd0, 14'd1);
		send_item(CMD_MARK, 13'd40, 14'd5);
		send_item(CMD_MARK, 13'd50, 14'd1);
		send_item(CMD_END, 13'd0, 14'd0);
		blocks_swept++;
	endtask

	// zero size, falling mark, remainder past the gap, edge cards, empty block
	task automatic test_corner_marks();
		send_item(CMD_MARK, 13'd100, 14'd0);
		send_item(CMD_MARK, 13'd90, 14'd3);
		send_item(CMD_MARK, 13'd95, LEN_MAX);
		send_item(CMD_END, CNT_MAX, LEN_MAX);
		send_item(CMD_MARK, CNT_MAX, 14'd8192);
		send_item(CMD_END, 13'd0, 14'd0);
		send_item(CMD_END, CNT_MAX, 14'd0);
		send_item(CMD_END, 13'd0, LEN_MAX);
		blocks_swept += 4;
	endtask

	task automatic test_min_extremes();
		set_min(14'd0);
		send_item(CMD_MARK, 13'd0, 14'd1);
		send_item(CMD_MARK, 13'd1, 14'd1);
		send_item(CMD_MARK, 13'd3, 14'd1);
		send_item(CMD_END, 13'd0, 14'd0);
		set_min(14'd8192);
		send_item(CMD_END, CNT_MAX, LEN_MAX);
		set_min(LEN_MAX);
		send_item(CMD_END, 13'd0, 14'd0);
		set_min(14'd1);
		blocks_swept += 3;
	endtask

	task automatic test_random_sweeps();
		while (items_sent < 1150) begin
			if (blocks_swept % 6 == 0)
				set_min(LEN_W'(pick_min()));
			case ($urandom_range(0, 2))
				0: tx_idle_pct = 0;
				1: tx_idle_pct = 10;
				default: tx_idle_pct = 40;
			endcase
			case ($urandom_range(0, 2))
				0: rx_stall_pct = 0;
				1: rx_stall_pct = 15;
				default: rx_stall_pct = 40;
			endcase
			sweep_block($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 4) == 0)
				hold_until_drained();
		end
	endtask

	// full rate on both sides
	task automatic test_back_to_back();
		set_min(LEN_W'($urandom_range(1, 64)));
		tx_idle_pct = 0;
		rx_quiet = 1'b1;
		while (items_sent < 1350)
			sweep_block(1'b0);
	endtask

	initial begin
		rx_stall_pct = 20;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_sweep();
		test_corner_marks();
		test_min_extremes();
		test_random_sweeps();
		test_back_to_back();
		hold_until_drained();
		$display("swept %0d items over %0d blocks, minimum free size from 0 to %0d",
			items_sent, blocks_swept, int'(LEN_MAX));
		$display("checked %0d free areas and %0d block summaries", areas_seen,
			summaries_seen);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
